/* rtl/core/gts_pkg.sv */
// ----------------------------------------------------------------------------
// Topological sort package
// Sizes, field widths and command codes shared by the sort engine files.
// ----------------------------------------------------------------------------
`default_nettype none

package gts_pkg;

  localparam int MAX_NODES = 32;
  localparam int MAX_EDGES = 128;

  localparam int NODE_W  = 5;
  localparam int COUNT_W = 6;
  localparam int SLOT_W  = 7;
  localparam int CMD_W   = 2;

  localparam int NODE_AW = $clog2(MAX_NODES);
  localparam int NCNT_W  = $clog2(MAX_NODES + 1);
  localparam int EDGE_AW = $clog2(MAX_EDGES);
  localparam int ETOT_W  = $clog2(MAX_EDGES + 1);
  localparam int DEG_W   = $clog2(MAX_EDGES + 1);
  localparam int EDGE_DW = 2 * NODE_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_SORT   = 2'd2,
    CMD_NONE   = 2'd3
  } command_t;

endpackage

`default_nettype wire

/* rtl/core/gts_ram.sv */
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/graph_topological_sort.sv */
// ----------------------------------------------------------------------------
// Graph topological sort
// Kahn sort over an edge table held in RAM, with indegree and queue RAMs.
// ----------------------------------------------------------------------------
// Clear and append are taken in the idle state; an append result appears next
// cycle. A sort clears the indegree RAM, counts indegrees over the edge table,
// queues the nodes of indegree zero, then for each ordered node walks the whole
// edge table through the one read port of the edge RAM. One request is processed
// at a time. Reset empties the edge table and the output register; the RAMs are
// not cleared, as every entry is written first.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_topological_sort (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [gts_pkg::CMD_W-1:0]   command,
  input  wire logic [gts_pkg::NODE_W-1:0]  from_node,
  input  wire logic [gts_pkg::NODE_W-1:0]  to_node,
  input  wire logic [gts_pkg::COUNT_W-1:0] node_count,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [gts_pkg::NODE_W-1:0]  sorted_node,
  output logic      [gts_pkg::COUNT_W-1:0] order_number,
  output logic      [gts_pkg::SLOT_W-1:0]  edge_slot,
  output logic                             is_status,
  output logic                             cycle_found,
  output logic                             table_full,
  output logic                             last
);

  import gts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_CNT_RD, S_CNT_EDGE, S_CNT_WR, S_SCAN_RD, S_SCAN_CHK,
    S_DQ, S_DQ_DATA, S_EMIT, S_W_RD, S_W_EDGE, S_W_DEG, S_FIN
  } state_t;

  state_t               state;
  logic [ETOT_W-1:0]    edge_total;
  logic [ETOT_W-1:0]    cnt_e;
  logic [NCNT_W-1:0]    cnt_n;
  logic [NCNT_W-1:0]    n_sat;
  logic [NCNT_W-1:0]    head;
  logic [NCNT_W-1:0]    tail;
  logic [NCNT_W-1:0]    done;
  logic [NODE_W-1:0]    u_node;
  logic [NODE_W-1:0]    e_tgt;

  logic                 e_we, e_re;
  logic [EDGE_AW-1:0]   e_waddr, e_raddr;
  logic [EDGE_DW-1:0]   e_wdata, e_rdata;
  logic                 d_we, d_re;
  logic [NODE_AW-1:0]   d_waddr, d_raddr;
  logic [DEG_W-1:0]     d_wdata, d_rdata;
  logic                 q_we, q_re;
  logic [NODE_AW-1:0]   q_waddr, q_raddr;
  logic [NODE_W-1:0]    q_wdata, q_rdata;

  logic                 out_free;
  logic                 accept;
  logic                 load_out;
  logic [NODE_W-1:0]    r_src, r_tgt;
  logic [NCNT_W-1:0]    cnt_sat;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign load_out = ((state == S_IDLE) && accept && (command == CMD_APPEND)) ||
                    (((state == S_EMIT) || (state == S_FIN)) && out_free);
  assign r_src    = e_rdata[EDGE_DW-1:NODE_W];
  assign r_tgt    = e_rdata[NODE_W-1:0];
  assign cnt_sat  = (NCNT_W'(node_count) > NCNT_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES)
                                                              : NCNT_W'(node_count);

  gts_ram #(.WIDTH(EDGE_DW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .re(e_re), .raddr(e_raddr), .rdata(e_rdata)
  );

  gts_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODES)) u_deg_ram (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .re(d_re), .raddr(d_raddr), .rdata(d_rdata)
  );

  gts_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .re(q_re), .raddr(q_raddr), .rdata(q_rdata)
  );

  always_comb begin
    e_we    = 1'b0;
    e_waddr = edge_total[EDGE_AW-1:0];
    e_wdata = {from_node, to_node};
    e_re    = 1'b0;
    e_raddr = cnt_e[EDGE_AW-1:0];
    d_we    = 1'b0;
    d_waddr = e_tgt[NODE_AW-1:0];
    d_wdata = '0;
    d_re    = 1'b0;
    d_raddr = r_tgt[NODE_AW-1:0];
    q_we    = 1'b0;
    q_waddr = tail[NODE_AW-1:0];
    q_wdata = e_tgt;
    q_re    = 1'b0;
    q_raddr = head[NODE_AW-1:0];
    unique case (state)
      S_IDLE: begin
        e_we = accept && (command == CMD_APPEND) &&
               (edge_total < ETOT_W'(MAX_EDGES));
      end
      S_CLR: begin
        d_we    = 1'b1;
        d_waddr = cnt_n[NODE_AW-1:0];
      end
      S_CNT_RD, S_W_RD: begin
        e_re = (cnt_e != edge_total);
      end
      S_CNT_EDGE: begin
        d_re = (NCNT_W'(r_src) < n_sat) && (NCNT_W'(r_tgt) < n_sat);
      end
      S_W_EDGE: begin
        d_re = (r_src == u_node) && (NCNT_W'(r_tgt) < n_sat);
      end
      S_CNT_WR: begin
        d_we    = 1'b1;
        d_wdata = d_rdata + DEG_W'(1);
      end
      S_SCAN_RD: begin
        d_re    = (cnt_n != n_sat);
        d_raddr = cnt_n[NODE_AW-1:0];
      end
      S_SCAN_CHK: begin
        q_we    = (d_rdata == '0) && (tail < NCNT_W'(MAX_NODES));
        q_wdata = NODE_W'(cnt_n);
      end
      S_DQ: begin
        q_re = (head < tail);
      end
      S_W_DEG: begin
        d_we    = (d_rdata != '0);
        d_wdata = d_rdata - DEG_W'(1);
        q_we    = (d_rdata == DEG_W'(1)) && (tail < NCNT_W'(MAX_NODES));
      end
      S_DQ_DATA, S_EMIT, S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      edge_total <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (command)
              CMD_CLEAR: begin
                edge_total <= '0;
              end
              CMD_APPEND: begin
                sorted_node  <= '0;
                order_number <= '0;
                is_status    <= 1'b1;
                cycle_found  <= 1'b0;
                last         <= 1'b1;
                if (edge_total < ETOT_W'(MAX_EDGES)) begin
                  edge_slot  <= edge_total[SLOT_W-1:0];
                  table_full <= 1'b0;
                  edge_total <= edge_total + ETOT_W'(1);
                end else begin
                  edge_slot  <= '0;
                  table_full <= 1'b1;
                end
              end
              CMD_SORT: begin
                n_sat <= cnt_sat;
                cnt_n <= '0;
                head  <= '0;
                tail  <= '0;
                done  <= '0;
                state <= S_CLR;
              end
              default: begin
              end
            endcase
          end
        end
        S_CLR: begin
          if (cnt_n == NCNT_W'(MAX_NODES - 1)) begin
            cnt_e <= '0;
            state <= S_CNT_RD;
          end else begin
            cnt_n <= cnt_n + NCNT_W'(1);
          end
        end
        S_CNT_RD: begin
          if (cnt_e == edge_total) begin
            cnt_n <= '0;
            state <= S_SCAN_RD;
          end else begin
            state <= S_CNT_EDGE;
          end
        end
        S_CNT_EDGE: begin
          e_tgt <= r_tgt;
          if ((NCNT_W'(r_src) < n_sat) && (NCNT_W'(r_tgt) < n_sat)) begin
            state <= S_CNT_WR;
          end else begin
            cnt_e <= cnt_e + ETOT_W'(1);
            state <= S_CNT_RD;
          end
        end
        S_CNT_WR: begin
          cnt_e <= cnt_e + ETOT_W'(1);
          state <= S_CNT_RD;
        end
        S_SCAN_RD: begin
          state <= (cnt_n == n_sat) ? S_DQ : S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if ((d_rdata == '0) && (tail < NCNT_W'(MAX_NODES))) begin
            tail <= tail + NCNT_W'(1);
          end
          cnt_n <= cnt_n + NCNT_W'(1);
          state <= S_SCAN_RD;
        end
        S_DQ: begin
          if (head < tail) begin
            head  <= head + NCNT_W'(1);
            state <= S_DQ_DATA;
          end else begin
            state <= S_FIN;
          end
        end
        S_DQ_DATA: begin
          u_node <= q_rdata;
          state  <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            sorted_node  <= u_node;
            order_number <= COUNT_W'(done) + COUNT_W'(1);
            edge_slot    <= '0;
            is_status    <= 1'b0;
            cycle_found  <= 1'b0;
            table_full   <= 1'b0;
            last         <= 1'b0;
            done         <= done + NCNT_W'(1);
            cnt_e        <= '0;
            state        <= S_W_RD;
          end
        end
        S_W_RD: begin
          state <= (cnt_e == edge_total) ? S_DQ : S_W_EDGE;
        end
        S_W_EDGE: begin
          e_tgt <= r_tgt;
          if ((r_src == u_node) && (NCNT_W'(r_tgt) < n_sat)) begin
            state <= S_W_DEG;
          end else begin
            cnt_e <= cnt_e + ETOT_W'(1);
            state <= S_W_RD;
          end
        end
        S_W_DEG: begin
          if ((d_rdata == DEG_W'(1)) && (tail < NCNT_W'(MAX_NODES))) begin
            tail <= tail + NCNT_W'(1);
          end
          cnt_e <= cnt_e + ETOT_W'(1);
          state <= S_W_RD;
        end
        S_FIN: begin
          if (out_free) begin
            sorted_node  <= '0;
            order_number <= COUNT_W'(done);
            edge_slot    <= '0;
            is_status    <= 1'b1;
            cycle_found  <= (done != n_sat);
            table_full   <= 1'b0;
            last         <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/gts_checker.sv */
// ----------------------------------------------------------------------------
// Topological sort port checker
// Watches the ports of the sort engine and flags results that break its rules.
// ----------------------------------------------------------------------------
`default_nettype none

module gts_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic [gts_pkg::CMD_W-1:0]   command,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [gts_pkg::NODE_W-1:0]  sorted_node,
  input wire logic [gts_pkg::COUNT_W-1:0] order_number,
  input wire logic [gts_pkg::SLOT_W-1:0]  edge_slot,
  input wire logic                        is_status,
  input wire logic                        cycle_found,
  input wire logic                        table_full,
  input wire logic                        last
);

  import gts_pkg::*;

  // A stalled result holds until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sorted_node) &&
      $stable(order_number) && $stable(edge_slot) && $stable(last))
  else $error("stalled result changed");

  // An accepted append request is acknowledged in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (command == CMD_APPEND) |=> out_valid && is_status && last)
  else $error("append request not acknowledged");

  // Node results never close a request and never flag a full table.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_status |-> !last && !table_full && !cycle_found)
  else $error("malformed node result");

  // A refused append is a final status with no slot.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> is_status && last && (edge_slot == '0) && !cycle_found)
  else $error("malformed refusal");

endmodule

bind graph_topological_sort gts_checker u_gts_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .command(command),
  .out_valid(out_valid), .out_stall(out_stall), .sorted_node(sorted_node),
  .order_number(order_number), .edge_slot(edge_slot), .is_status(is_status),
  .cycle_found(cycle_found), .table_full(table_full), .last(last)
);

`default_nettype wire
